// ----- rtl/srcp_pkg.sv -----
// ----------------------------------------------------------------------------
// srcp_pkg: shared types and constants for the sprite corner point block
// Beat layouts, pipeline payloads, fixed-point constants and the CORDIC
// arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package srcp_pkg;

   // Beat widths on the stream ports
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 48;

   // CORDIC datapath widths (Q30 vector and angle)
   localparam int XW = 34;
   localparam int ZW = 34;

   // Fixed-point constants
   localparam logic signed [XW-1:0] CORDIC_GAIN  = 34'sd652032874;
   localparam logic signed [19:0]   RAD_PER_UNIT = 20'sd292818;
   localparam logic signed [16:0]   ANG_FULL     = 17'sd23040;
   localparam logic signed [16:0]   ANG_HALF     = 17'sd11520;
   localparam logic signed [16:0]   ANG_QUARTER  = 17'sd5760;

   // Corner codes, in emission order
   localparam logic [1:0] CORNER_UL = 2'd0;
   localparam logic [1:0] CORNER_UR = 2'd1;
   localparam logic [1:0] CORNER_LL = 2'd2;

   // Request beat, laid out so that angle sits in the lowest bits
   typedef struct packed {
      logic signed [15:0] display_y;
      logic signed [15:0] display_x;
      logic        [15:0] scale;
      logic        [11:0] image_height;
      logic        [11:0] image_width;
      logic        [11:0] pivot_y;
      logic        [11:0] pivot_x;
      logic signed [15:0] angle;
   } req_type;

   // Sprite geometry that rides along the rotation chain
   typedef struct packed {
      logic               neg;
      logic        [19:0] px;
      logic        [19:0] py;
      logic        [27:0] wq;
      logic        [27:0] hq;
      logic signed [15:0] dxp;
      logic signed [15:0] dyp;
   } side_type;

   // Contents of one rotation cell
   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      side_type             side;
   } rot_type;

   // Three finished corners of one sprite
   typedef struct packed {
      logic [2:0][21:0] cx;
      logic [2:0][21:0] cy;
   } corners_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [ZW-1:0] v;
      case (idx)
         5'd0:    v = 34'sd843314856;
         5'd1:    v = 34'sd497837829;
         5'd2:    v = 34'sd263043836;
         5'd3:    v = 34'sd133525158;
         5'd4:    v = 34'sd67021686;
         5'd5:    v = 34'sd33543515;
         5'd6:    v = 34'sd16775850;
         5'd7:    v = 34'sd8388437;
         5'd8:    v = 34'sd4194282;
         5'd9:    v = 34'sd2097149;
         5'd10:   v = 34'sd1048575;
         5'd11:   v = 34'sd524287;
         5'd12:   v = 34'sd262143;
         5'd13:   v = 34'sd131071;
         5'd14:   v = 34'sd65535;
         5'd15:   v = 34'sd32767;
         5'd16:   v = 34'sd16383;
         5'd17:   v = 34'sd8191;
         5'd18:   v = 34'sd4095;
         5'd19:   v = 34'sd2047;
         5'd20:   v = 34'sd1023;
         5'd21:   v = 34'sd511;
         5'd22:   v = 34'sd255;
         5'd23:   v = 34'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/srcp_prep.sv -----
// ----------------------------------------------------------------------------
// srcp_prep: angle folding and sprite scaling
// Two stages: fold the angle into plus or minus 90 degrees and scale the
// pivot and size, then turn the angle into Q30 radians for the CORDIC chain.
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_prep (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  wire                 in_valid,
   input  srcp_pkg::req_type   in_data,
   output logic                out_valid,
   output srcp_pkg::rot_type   out_data
);

   logic                 v1_ff;
   logic signed [13:0]   r_ff;
   logic signed [13:0]   r_in;
   srcp_pkg::side_type   side_ff;
   srcp_pkg::side_type   side_in;
   logic                 v2_ff;
   srcp_pkg::rot_type    rot_ff;
   srcp_pkg::rot_type    rot_in;

   logic signed [16:0]   u;
   logic signed [16:0]   r1;
   logic signed [16:0]   r2;
   logic                 neg;
   logic        [27:0]   px_full;
   logic        [27:0]   py_full;

   // Fold the angle and scale pivot and size
   always_comb begin
      u = 17'(in_data.angle);
      if (u <= -srcp_pkg::ANG_HALF) begin
         r1 = u + srcp_pkg::ANG_FULL;
      end else if (u > srcp_pkg::ANG_HALF) begin
         r1 = u - srcp_pkg::ANG_FULL;
      end else begin
         r1 = u;
      end
      neg = 1'b0;
      if (r1 > srcp_pkg::ANG_QUARTER) begin
         r2  = r1 - srcp_pkg::ANG_HALF;
         neg = 1'b1;
      end else if (r1 < -srcp_pkg::ANG_QUARTER) begin
         r2  = r1 + srcp_pkg::ANG_HALF;
         neg = 1'b1;
      end else begin
         r2 = r1;
      end
      r_in = 14'(r2);

      px_full      = 28'(in_data.pivot_x) * 28'(in_data.scale);
      py_full      = 28'(in_data.pivot_y) * 28'(in_data.scale);
      side_in.neg  = neg;
      side_in.px   = px_full[27:8];
      side_in.py   = py_full[27:8];
      side_in.wq   = 28'(in_data.image_width) * 28'(in_data.scale);
      side_in.hq   = 28'(in_data.image_height) * 28'(in_data.scale);
      side_in.dxp  = in_data.display_x;
      side_in.dyp  = in_data.display_y;
   end

   // Seed the rotation vector
   always_comb begin
      rot_in.x    = srcp_pkg::CORDIC_GAIN;
      rot_in.y    = '0;
      rot_in.z    = 34'(r_ff) * 34'(srcp_pkg::RAD_PER_UNIT);
      rot_in.side = side_ff;
   end

   // Advance both stages together
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
      if (advance) begin
         r_ff    <= r_in;
         side_ff <= side_in;
         rot_ff  <= rot_in;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = rot_ff;

endmodule

`default_nettype wire

// ----- rtl/srcp_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// srcp_cordic_cell: one CORDIC rotation step
// Rotates the vector by plus or minus atan(2^-STEP) toward zero residual
// angle and hands the result and the sprite geometry to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_cordic_cell #(
   parameter int STEP = 0
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 advance,
   input  wire                 in_valid,
   input  srcp_pkg::rot_type   in_data,
   output logic                out_valid,
   output srcp_pkg::rot_type   out_data
);

   localparam logic signed [srcp_pkg::ZW-1:0] ATAN = srcp_pkg::atan_q30(5'(STEP));

   logic                valid_ff;
   srcp_pkg::rot_type   data_ff;
   srcp_pkg::rot_type   data_in;

   // Rotate toward the residual angle sign
   always_comb begin
      data_in = in_data;
      if (!in_data.z[srcp_pkg::ZW-1]) begin
         data_in.x = in_data.x - (in_data.y >>> STEP);
         data_in.y = in_data.y + (in_data.x >>> STEP);
         data_in.z = in_data.z - ATAN;
      end else begin
         data_in.x = in_data.x + (in_data.y >>> STEP);
         data_in.y = in_data.y - (in_data.x >>> STEP);
         data_in.z = in_data.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- rtl/srcp_corner.sv -----
// ----------------------------------------------------------------------------
// srcp_corner: corner arithmetic after the rotation chain
// Six stages: round sine and cosine to Q1.16, form the offset products,
// sum the base corner, add width and height terms, truncate toward zero,
// then add the display point and saturate to 22 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_corner (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire                   in_valid,
   input  srcp_pkg::rot_type     in_data,
   output logic                  out_valid,
   output srcp_pkg::corners_type out_corners
);

   logic [5:0]          valid_ff;

   // stage 1: sine, cosine
   logic signed [17:0]  c_ff, c_in, s_ff, s_in;
   srcp_pkg::side_type  side1_ff;
   // stage 2: products
   logic signed [38:0]  pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [46:0]  pe_ff, pf_ff, pg_ff, ph_ff;
   logic        [19:0]  px2_ff, py2_ff;
   logic signed [15:0]  dxp2_ff, dyp2_ff;
   // stage 3: base corner
   logic signed [47:0]  rx0_ff, ry0_ff, rx0_in, ry0_in;
   logic signed [46:0]  pe3_ff, pf3_ff, pg3_ff, ph3_ff;
   logic signed [21:0]  bx3_ff, by3_ff, bx_in, by_in;
   // stage 4: three corners before truncation
   logic signed [47:0]  rx4_ff [3];
   logic signed [47:0]  ry4_ff [3];
   logic signed [21:0]  bx4_ff, by4_ff;
   // stage 5: truncated offsets
   logic signed [23:0]  tx5_ff [3];
   logic signed [23:0]  ty5_ff [3];
   logic signed [21:0]  bx5_ff, by5_ff;
   // stage 6: finished corners
   srcp_pkg::corners_type corners_ff, corners_in;

   logic signed [srcp_pkg::XW-1:0] xr, yr;
   logic signed [20:0]  px_s, py_s;
   logic signed [28:0]  wq_s, hq_s;

   function automatic logic signed [17:0] clamp18(input logic signed [19:0] v);
      logic signed [17:0] r;
      if (v > 20'sd65536) begin
         r = 18'sd65536;
      end else if (v < -20'sd65536) begin
         r = -18'sd65536;
      end else begin
         r = 18'(v);
      end
      return r;
   endfunction

   // Truncate a Q24 value toward zero
   function automatic logic signed [23:0] trunc24(input logic signed [47:0] v);
      logic signed [47:0] b;
      b = v + (v[47] ? 48'sd16777215 : 48'sd0);
      return b[47:24];
   endfunction

   function automatic logic [21:0] sat22(input logic signed [24:0] v);
      logic [21:0] r;
      if (v > 25'sd2097151) begin
         r = 22'h1FFFFF;
      end else if (v < -25'sd2097152) begin
         r = 22'h200000;
      end else begin
         r = v[21:0];
      end
      return r;
   endfunction

   // Round, clamp and fold the sign of cosine and sine
   always_comb begin
      xr   = (in_data.x + 34'sd8192) >>> 14;
      yr   = (in_data.y + 34'sd8192) >>> 14;
      c_in = clamp18(xr[19:0]);
      s_in = clamp18(yr[19:0]);
      if (in_data.side.neg) begin
         c_in = -c_in;
         s_in = -s_in;
      end
   end

   assign px_s = signed'({1'b0, side1_ff.px});
   assign py_s = signed'({1'b0, side1_ff.py});
   assign wq_s = signed'({1'b0, side1_ff.wq});
   assign hq_s = signed'({1'b0, side1_ff.hq});

   // Form the base corner and the pivot correction
   always_comb begin
      rx0_in = ((48'(pd_ff) - 48'(pa_ff)) <<< 8) + signed'(48'({px2_ff, 24'h000000}));
      ry0_in = signed'(48'({py2_ff, 24'h000000})) - ((48'(pb_ff) + 48'(pc_ff)) <<< 8);
      bx_in  = 22'(dxp2_ff) - signed'({2'b00, px2_ff});
      by_in  = 22'(dyp2_ff) - signed'({2'b00, py2_ff});
   end

   // Add the display base and saturate
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         corners_in.cx[k] = sat22(25'(bx5_ff) + 25'(tx5_ff[k]));
         corners_in.cy[k] = sat22(25'(by5_ff) + 25'(ty5_ff[k]));
      end
   end

   // Shift valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   // Advance the datapath stages
   always_ff @(posedge clock) begin
      if (advance) begin
         c_ff     <= c_in;
         s_ff     <= s_in;
         side1_ff <= in_data.side;

         pa_ff   <= 39'(px_s) * 39'(c_ff);
         pb_ff   <= 39'(px_s) * 39'(s_ff);
         pc_ff   <= 39'(py_s) * 39'(c_ff);
         pd_ff   <= 39'(py_s) * 39'(s_ff);
         pe_ff   <= 47'(wq_s) * 47'(c_ff);
         pf_ff   <= 47'(wq_s) * 47'(s_ff);
         pg_ff   <= 47'(hq_s) * 47'(c_ff);
         ph_ff   <= 47'(hq_s) * 47'(s_ff);
         px2_ff  <= side1_ff.px;
         py2_ff  <= side1_ff.py;
         dxp2_ff <= side1_ff.dxp;
         dyp2_ff <= side1_ff.dyp;

         rx0_ff <= rx0_in;
         ry0_ff <= ry0_in;
         pe3_ff <= pe_ff;
         pf3_ff <= pf_ff;
         pg3_ff <= pg_ff;
         ph3_ff <= ph_ff;
         bx3_ff <= bx_in;
         by3_ff <= by_in;

         rx4_ff[0] <= rx0_ff;
         ry4_ff[0] <= ry0_ff;
         rx4_ff[1] <= rx0_ff + 48'(pe3_ff);
         ry4_ff[1] <= ry0_ff + 48'(pf3_ff);
         rx4_ff[2] <= rx0_ff - 48'(ph3_ff);
         ry4_ff[2] <= ry0_ff + 48'(pg3_ff);
         bx4_ff    <= bx3_ff;
         by4_ff    <= by3_ff;

         for (int k = 0; k < 3; k++) begin
            tx5_ff[k] <= trunc24(rx4_ff[k]);
            ty5_ff[k] <= trunc24(ry4_ff[k]);
         end
         bx5_ff <= bx4_ff;
         by5_ff <= by4_ff;

         corners_ff <= corners_in;
      end
   end

   assign out_valid   = valid_ff[5];
   assign out_corners = corners_ff;

endmodule

`default_nettype wire

// ----- rtl/srcp_beat_out.sv -----
// ----------------------------------------------------------------------------
// srcp_beat_out: corner result serializer
// Holds the three corners of one sprite and sends them as three beats,
// upper left, upper right, lower left, taking the next sprite on the last.
// ----------------------------------------------------------------------------
`default_nettype none

module srcp_beat_out (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 in_valid,
   input  srcp_pkg::corners_type               in_corners,
   output logic                                take,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [srcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast
);

   logic                  full_ff, full_in;
   logic [1:0]            beat_ff, beat_in;
   srcp_pkg::corners_type corners_ff;
   logic                  finish;
   logic [21:0]           x_sel, y_sel;

   // Take a new sprite when empty or when the last beat leaves
   always_comb begin
      finish  = full_ff && rsp_tready && (beat_ff == srcp_pkg::CORNER_LL);
      take    = in_valid && (!full_ff || finish);
      full_in = full_ff;
      beat_in = beat_ff;
      if (take) begin
         full_in = 1'b1;
         beat_in = srcp_pkg::CORNER_UL;
      end else if (finish) begin
         full_in = 1'b0;
      end else if (full_ff && rsp_tready) begin
         beat_in = beat_ff + 2'd1;
      end
   end

   // Select the corner of the current beat
   always_comb begin
      case (beat_ff)
         srcp_pkg::CORNER_UL: begin
            x_sel = corners_ff.cx[0];
            y_sel = corners_ff.cy[0];
         end
         srcp_pkg::CORNER_UR: begin
            x_sel = corners_ff.cx[1];
            y_sel = corners_ff.cy[1];
         end
         default: begin
            x_sel = corners_ff.cx[2];
            y_sel = corners_ff.cy[2];
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         beat_ff <= srcp_pkg::CORNER_UL;
      end else begin
         full_ff <= full_in;
         beat_ff <= beat_in;
      end
      if (take) begin
         corners_ff <= in_corners;
      end
   end

   assign rsp_tvalid = full_ff;
   assign rsp_tdata  = {4'h0, y_sel, x_sel};
   assign rsp_tuser  = beat_ff;
   assign rsp_tlast  = (beat_ff == srcp_pkg::CORNER_LL);

   // Corners of one sprite go out in order
   a_beat_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast
      |=> rsp_tvalid && (rsp_tuser == $past(rsp_tuser) + 2'd1))
      else $error("corner beats out of order");

   // A new sprite always starts at the upper left corner
   a_start_ul: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_tvalid && (rsp_tuser == srcp_pkg::CORNER_UL))
      else $error("sprite did not start at upper left");

   // Drain to empty when the last beat leaves and nothing is waiting
   a_drain: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast && !take |=> !rsp_tvalid)
      else $error("result held after last beat");

endmodule

`default_nettype wire

// ----- rtl/sprite_rotate_corner_points.sv -----
// ----------------------------------------------------------------------------
// sprite_rotate_corner_points: rotated, scaled sprite corner points
// Scales a sprite, rotates it about its scaled pivot with a pipelined CORDIC
// and returns its upper left, upper right and lower left screen corners.
//
//   channel  dir  beat contents                         per sprite
//   req      in   angle, pivot, size, scale, display    1 beat
//   rsp      out  corner x, y; tuser corner; tlast      3 beats
//
// Sustained sprite rate is set by the single result port, which sends
// three corner beats per sprite. A request passes through 2 prep stages,
// one cell per CORDIC step, 6 corner stages and the output register
// before its first corner leaves.
// Reset clears the valid flags and the beat counter, which empties the
// pipeline.
// A stalled result freezes the whole pipeline once a finished sprite waits
// behind the one being sent; req_tready drops only then.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_rotate_corner_points #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire                                 clock,
   input  wire                                 reset,
   // angle[15:0] pivot_x[27:16] pivot_y[39:28] image_width[51:40]
   // image_height[63:52] scale[79:64] display_x[95:80] display_y[111:96]
   input  wire  [srcp_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // corner_x[21:0] corner_y[43:22], zero above
   output logic [srcp_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // corner_index[1:0]
   output logic [1:0]                          rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready
);

   logic                  advance;
   logic                  rot_valid [CORDIC_STEPS+1];
   srcp_pkg::rot_type     rot_data  [CORDIC_STEPS+1];
   logic                  corner_valid;
   srcp_pkg::corners_type corners;
   logic                  ser_take;

   // Move the whole pipeline unless a finished sprite cannot be handed over
   assign advance    = !corner_valid || ser_take;
   assign req_tready = advance;

   srcp_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_tvalid),
      .in_data   (srcp_pkg::req_type'(req_tdata)),
      .out_valid (rot_valid[0]),
      .out_data  (rot_data[0])
   );

   // Chain of rotation cells, one per CORDIC step
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      srcp_cordic_cell #(
         .STEP (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (rot_valid[i]),
         .in_data   (rot_data[i]),
         .out_valid (rot_valid[i+1]),
         .out_data  (rot_data[i+1])
      );
   end

   srcp_corner u_corner (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (rot_valid[CORDIC_STEPS]),
      .in_data     (rot_data[CORDIC_STEPS]),
      .out_valid   (corner_valid),
      .out_corners (corners)
   );

   srcp_beat_out u_beat_out (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (corner_valid),
      .in_corners (corners),
      .take       (ser_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Hold off requests while a finished sprite waits behind the current one
   a_hold_req: assert property (@(posedge clock) disable iff (reset)
      corner_valid && rsp_tvalid && !(rsp_tready && rsp_tlast) |-> !req_tready)
      else $error("pipeline advanced over a waiting sprite");

endmodule

`default_nettype wire
